### rtl/fld_pkg.sv
// shared constants for the fuzzy level danger estimator
package fld_pkg;

  // field and bus widths
  localparam int unsigned DIST_W      = 12;
  localparam int unsigned LEVEL_W     = 15;
  localparam int unsigned LEVEL_FRAC  = 8;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  // valid measuring range, upper end in mm
  localparam int unsigned RANGE_MAX_MM = 4000;

  // safe set: rising edge between these corners, flat above
  localparam int unsigned SAFE_A    = 200;
  localparam int unsigned SAFE_B    = 250;
  localparam int unsigned SAFE_SPAN = SAFE_B - SAFE_A;

  // warning set: triangle
  localparam int unsigned WARN_A    = 100;
  localparam int unsigned WARN_B    = 180;
  localparam int unsigned WARN_C    = 260;
  localparam int unsigned WARN_SPAN = WARN_B - WARN_A;

  // danger set: flat from 1 mm, falling edge between these corners
  localparam int unsigned DANGER_C    = 100;
  localparam int unsigned DANGER_D    = 150;
  localparam int unsigned DANGER_SPAN = DANGER_D - DANGER_C;

  // rule consequents
  localparam int unsigned W_SAFE   = 10;
  localparam int unsigned W_WARN   = 50;
  localparam int unsigned W_DANGER = 90;

  // largest level the weighted average can reach
  localparam int unsigned LEVEL_MAX = W_DANGER << LEVEL_FRAC;

endpackage

### rtl/fld_div.sv
// pipelined restoring divider, one quotient bit per stage
module fld_div #(
  parameter int GRADE_FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [GRADE_FRAC_BITS+7:0]      in_num,
  input  logic [GRADE_FRAC_BITS+1:0]      in_sum,
  input  logic                            in_flag,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fld_pkg::LEVEL_W-1:0]     out_quo,
  output logic                            out_flag
);
  import fld_pkg::*;

  localparam int unsigned G      = GRADE_FRAC_BITS;
  localparam int unsigned NUM_W  = G + 8;
  localparam int unsigned SUM_W  = G + 2;
  localparam int unsigned DVD_W  = NUM_W + LEVEL_FRAC;
  localparam int unsigned STAGES = LEVEL_W;

  // per stage state
  logic [SUM_W-1:0]   rem_r  [STAGES];
  logic [LEVEL_W-1:0] dlo_r  [STAGES];
  logic [LEVEL_W-1:0] quo_r  [STAGES];
  logic [SUM_W-1:0]   sum_r  [STAGES];
  logic [STAGES-1:0]  flag_r;
  logic [STAGES-1:0]  v_r;
  logic [STAGES:0]    rdy;
  logic [DVD_W-1:0]   dvd;

  // dividend is the numerator scaled by the level fraction
  assign dvd = {in_num, LEVEL_FRAC'(0)};

  // a stage moves when it is empty or the next one moves
  assign rdy[STAGES] = out_ready;
  assign in_ready    = rdy[0];

  for (genvar k = 0; k < STAGES; k++) begin : g_st
    logic [SUM_W-1:0]   s_rem;
    logic [LEVEL_W-1:0] s_dlo;
    logic [LEVEL_W-1:0] s_quo;
    logic [SUM_W-1:0]   s_sum;
    logic               s_flag;
    logic               s_v;
    logic [SUM_W:0]     trial;
    logic               fits;
    logic [SUM_W-1:0]   rem_nxt;
    logic [LEVEL_W-1:0] dlo_nxt;
    logic [LEVEL_W-1:0] quo_nxt;

    // source of this stage
    if (k == 0) begin : g_src0
      assign s_rem  = SUM_W'(dvd[DVD_W-1:LEVEL_W]);
      assign s_dlo  = dvd[LEVEL_W-1:0];
      assign s_quo  = '0;
      assign s_sum  = in_sum;
      assign s_flag = in_flag;
      assign s_v    = in_valid;
    end else begin : g_srcn
      assign s_rem  = rem_r[k-1];
      assign s_dlo  = dlo_r[k-1];
      assign s_quo  = quo_r[k-1];
      assign s_sum  = sum_r[k-1];
      assign s_flag = flag_r[k-1];
      assign s_v    = v_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
      trial   = {s_rem, s_dlo[LEVEL_W-1]};
      fits    = trial >= {1'b0, s_sum};
      rem_nxt = fits ? SUM_W'(trial - {1'b0, s_sum}) : trial[SUM_W-1:0];
      dlo_nxt = {s_dlo[LEVEL_W-2:0], 1'b0};
      quo_nxt = {s_quo[LEVEL_W-2:0], fits};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= s_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && s_v) begin
        rem_r[k]  <= rem_nxt;
        dlo_r[k]  <= dlo_nxt;
        quo_r[k]  <= quo_nxt;
        sum_r[k]  <= s_sum;
        flag_r[k] <= s_flag;
      end
    end
  end

  // last stage is the output register
  assign out_valid = v_r[STAGES-1];
  assign out_quo   = quo_r[STAGES-1];
  assign out_flag  = flag_r[STAGES-1];

endmodule

### rtl/fuzzy_level_danger_estimator.sv
// fuzzy water level danger estimator, top level
//
//  channel | direction | tdata                      | tuser
//  --------+-----------+----------------------------+-------------------
//  in_     | slave     | [11:0] distance_mm         | none
//  out_    | master    | [14:0] danger_level (Q7.8) | [0] out_of_range
//
// one item enters per cycle unless out_tready has held the full pipeline; an item passes
// through 18 register stages: input register, grade stage, weighted-sum stage, then 15
// divider stages of one quotient bit each, the last being the output register.
// the divider compare/subtract of the grade sum sets the stage depth.
// rst_n clears all stage valid bits; payload registers are not reset.
// a stalled output holds its item; empty stages keep filling while out_tready is low.
module fuzzy_level_danger_estimator #(
  parameter int GRADE_FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fld_pkg::IN_TDATA_W-1:0]  in_tdata,   // [11:0] distance_mm
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fld_pkg::OUT_TDATA_W-1:0] out_tdata,  // [14:0] danger_level
  output logic                            out_tuser   // [0] out_of_range
);
  import fld_pkg::*;

  localparam int unsigned G         = GRADE_FRAC_BITS;
  localparam int unsigned GR_W      = G + 1;
  localparam int unsigned SUM_W     = G + 2;
  localparam int unsigned NUM_W     = G + 8;
  localparam int unsigned SAFE_IW   = $clog2(SAFE_SPAN);
  localparam int unsigned WARN_IW   = $clog2(WARN_SPAN);
  localparam int unsigned DANGER_IW = $clog2(DANGER_SPAN);
  localparam logic [GR_W-1:0] GRADE_ONE = GR_W'(1) << G;

  // edge tables: (d << G) / span
  logic [G-1:0] t_safe   [SAFE_SPAN];
  logic [G-1:0] t_warn   [WARN_SPAN];
  logic [G-1:0] t_danger [DANGER_SPAN];

  for (genvar i = 0; i < SAFE_SPAN; i++) begin : g_tsafe
    localparam int unsigned TV = (i << G) / SAFE_SPAN;
    assign t_safe[i] = G'(TV);
  end
  for (genvar i = 0; i < WARN_SPAN; i++) begin : g_twarn
    localparam int unsigned TV = (i << G) / WARN_SPAN;
    assign t_warn[i] = G'(TV);
  end
  for (genvar i = 0; i < DANGER_SPAN; i++) begin : g_tdanger
    localparam int unsigned TV = (i << G) / DANGER_SPAN;
    assign t_danger[i] = G'(TV);
  end

  // stage registers
  logic [DIST_W-1:0] x_r;
  logic              va_r;
  logic [GR_W-1:0]   gs_r, gw_r, gd_r;
  logic              oorb_r;
  logic              vb_r;
  logic [NUM_W-1:0]  num_r;
  logic [SUM_W-1:0]  sum_r;
  logic              oorc_r;
  logic              vc_r;

  logic              rdy_a, rdy_b, rdy_c;
  logic              div_ready;
  logic [GR_W-1:0]   gs_nxt, gw_nxt, gd_nxt;
  logic              oor_nxt;
  logic [NUM_W-1:0]  num_nxt;
  logic [SUM_W-1:0]  sum_nxt;
  logic [LEVEL_W-1:0] quo;

  // per stage ready chain
  assign rdy_c     = !vc_r || div_ready;
  assign rdy_b     = !vb_r || rdy_c;
  assign rdy_a     = !va_r || rdy_b;
  assign in_tready = rdy_a;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (rdy_a) begin
      va_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_tvalid) begin
      x_r <= in_tdata[DIST_W-1:0];
    end
  end

  // membership grades
  always_comb begin
    oor_nxt = (x_r == '0) || (x_r > DIST_W'(RANGE_MAX_MM));

    // safe: rises from 200 to 250, flat to the end of the range
    if (x_r <= DIST_W'(SAFE_A)) begin
      gs_nxt = '0;
    end else if (x_r < DIST_W'(SAFE_B)) begin
      gs_nxt = {1'b0, t_safe[SAFE_IW'(x_r - DIST_W'(SAFE_A))]};
    end else begin
      gs_nxt = GRADE_ONE;
    end

    // warning: triangle with its peak at 180
    if (x_r <= DIST_W'(WARN_A) || x_r >= DIST_W'(WARN_C)) begin
      gw_nxt = '0;
    end else if (x_r < DIST_W'(WARN_B)) begin
      gw_nxt = {1'b0, t_warn[WARN_IW'(x_r - DIST_W'(WARN_A))]};
    end else if (x_r == DIST_W'(WARN_B)) begin
      gw_nxt = GRADE_ONE;
    end else begin
      gw_nxt = {1'b0, t_warn[WARN_IW'(DIST_W'(WARN_C) - x_r)]};
    end

    // danger: flat up to 100, falls to 150
    if (x_r <= DIST_W'(DANGER_C)) begin
      gd_nxt = GRADE_ONE;
    end else if (x_r < DIST_W'(DANGER_D)) begin
      gd_nxt = {1'b0, t_danger[DANGER_IW'(DIST_W'(DANGER_D) - x_r)]};
    end else begin
      gd_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (rdy_b) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_b && va_r) begin
      gs_r   <= gs_nxt;
      gw_r   <= gw_nxt;
      gd_r   <= gd_nxt;
      oorb_r <= oor_nxt;
    end
  end

  // weighted sum and grade sum; out of range or empty sum divides 0 by 1
  always_comb begin
    sum_nxt = SUM_W'(gs_r) + SUM_W'(gw_r) + SUM_W'(gd_r);
    num_nxt = NUM_W'(gs_r) * NUM_W'(W_SAFE) + NUM_W'(gw_r) * NUM_W'(W_WARN)
            + NUM_W'(gd_r) * NUM_W'(W_DANGER);
    if (oorb_r || sum_nxt == '0) begin
      num_nxt = '0;
      sum_nxt = SUM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (rdy_c) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && vb_r) begin
      num_r  <= num_nxt;
      sum_r  <= sum_nxt;
      oorc_r <= oorb_r;
    end
  end

  // level = (num << 8) / sum
  fld_div #(
    .GRADE_FRAC_BITS (GRADE_FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vc_r),
    .in_ready  (div_ready),
    .in_num    (num_r),
    .in_sum    (sum_r),
    .in_flag   (oorc_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_quo   (quo),
    .out_flag  (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'(quo);

endmodule

### rtl/fld_checker.sv
// port-level checks for the fuzzy level danger estimator, bound to the top level
module fld_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [fld_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fld_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);
  import fld_pkg::*;

  // a held result keeps its level and flag
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("output item changed while stalled");

  // an offered input item waits unchanged until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("input item changed while stalled");

  // the input side only backs up when the output is stalled
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled with output free");

  // out of range items carry level zero
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("out of range item with nonzero level");

  // level never exceeds the largest consequent
  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= OUT_TDATA_W'(LEVEL_MAX))
    else $error("level above maximum");

endmodule

bind fuzzy_level_danger_estimator fld_checker u_fld_checker (.*);

### tb/testbench.sv
// self-checking testbench for the fuzzy level danger estimator
`timescale 1ns / 1ps

typedef struct packed {
  logic [14:0] danger_level;
  logic        out_of_range;
} level_result_t;

// predicts the level for each accepted distance and checks results in order
class level_scoreboard;
  localparam int unsigned GRADE_FRAC = 8;
  localparam longint unsigned GRADE_ONE = 64'd1 << GRADE_FRAC;

  level_result_t pending_levels[$];
  int unsigned   errors;
  int unsigned   checked;
  int unsigned   oor_samples;

  // trapezoid grade, zero at and beyond the outer corners
  function longint unsigned trap_grade(longint unsigned x, longint unsigned a,
                                       longint unsigned b, longint unsigned c,
                                       longint unsigned d);
    if (x <= a || x >= d) return 0;
    if (x >= b && x <= c) return GRADE_ONE;
    if (x < b) return ((x - a) << GRADE_FRAC) / (b - a);
    return ((d - x) << GRADE_FRAC) / (d - c);
  endfunction

  // weighted average of the three rule grades
  function level_result_t predict_level(logic [11:0] dist_mm);
    level_result_t   res;
    longint unsigned x, g_safe, g_warn, g_danger, g_sum, weighted;
    x   = dist_mm;
    res = '0;
    if (x == 0 || x > 4000) begin
      res.out_of_range = 1'b1;
      return res;
    end
    g_safe   = trap_grade(x, 200, 250, 4000, 4010);
    g_danger = trap_grade(x, 0, 1, 100, 150);
    // warning triangle with its peak at 180 mm
    if (x <= 100 || x >= 260) g_warn = 0;
    else if (x == 180) g_warn = GRADE_ONE;
    else if (x < 180) g_warn = ((x - 100) << GRADE_FRAC) / 80;
    else g_warn = ((260 - x) << GRADE_FRAC) / 80;
    g_sum = g_safe + g_warn + g_danger;
    if (g_sum != 0) begin
      weighted = 10 * g_safe + 50 * g_warn + 90 * g_danger;
      res.danger_level = 15'(((weighted << 8) / g_sum) & 64'h7FFF);
    end
    return res;
  endfunction

  function void note_sample(logic [11:0] dist_mm);
    level_result_t res;
    res = predict_level(dist_mm);
    if (res.out_of_range) oor_samples++;
    pending_levels.push_back(res);
  endfunction

  function void check_result(logic [14:0] level, logic oor);
    level_result_t exp_res;
    checked++;
    if (pending_levels.size() == 0) begin
      $error("unexpected item: danger_level %0d, out_of_range %0d", level, oor);
      errors++;
      return;
    end
    exp_res = pending_levels.pop_front();
    if (level !== exp_res.danger_level) begin
      $error("danger_level: expected %0d, got %0d", exp_res.danger_level, level);
      errors++;
    end
    if (oor !== exp_res.out_of_range) begin
      $error("out_of_range: expected %0d, got %0d", exp_res.out_of_range, oor);
      errors++;
    end
  endfunction
endclass

module testbench;
  import fld_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int RANDOM_ITEMS = 1600;
  localparam int DRAIN_CYCLES = 40;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  level_scoreboard sb = new();
  int unsigned     items_sent;
  int unsigned     input_stalls;
  int unsigned     results_seen;

  fuzzy_level_danger_estimator #(
    .GRADE_FRAC_BITS(8)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // input side monitor
  always @(posedge clk) begin
    if (rst_n && in_tvalid) begin
      if (in_tready) sb.note_sample(in_tdata[DIST_W-1:0]);
      else input_stalls++;
    end
  end

  // output side monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      sb.check_result(out_tdata[LEVEL_W-1:0], out_tuser);
    end
  end

  // offer one distance, optionally after a short random gap
  task automatic send_distance(input logic [DIST_W-1:0] dist_mm, input bit may_idle);
    int unsigned gap;
    gap = (may_idle && $urandom_range(99) < 33) ? $urandom_range(3, 1) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - DIST_W){1'b0}}, dist_mm};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // random distance, weighted toward the region where the sets overlap
  function automatic logic [DIST_W-1:0] pick_distance();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return DIST_W'($urandom_range(300, 0));
    if (r < 85) return DIST_W'($urandom_range(4000, 1));
    return DIST_W'($urandom_range(4095, 0));
  endfunction

  // receiver: random back-pressure, one long hold-off, one calm stretch
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (!hold_done && results_seen >= 300) begin
        hold_done = 1;
        hold_left = 400;
        out_tready <= 1'b0;
      end else if (results_seen >= 800 && results_seen < 1100) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 33);
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [DIST_W-1:0] corners[$];
    corners = '{0, 1, 2, 99, 100, 101, 149, 150, 151, 179, 180, 181, 199, 200,
                201, 249, 250, 259, 260, 261, 2730, 4000, 4001, 4010, 4095};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners of every set and the range limits
    foreach (corners[i]) send_distance(corners[i], 1'b1);

    // random samples, with one stretch of back-to-back items
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_distance(pick_distance(), !(i >= 700 && i < 1000));
    end
    in_tvalid <= 1'b0;

    // drain the pipeline and watch for stray items
    while (sb.pending_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d distance samples, %0d of them out of range",
             items_sent, sb.oor_samples);
    $display("checked %0d results, input held back for %0d cycles",
             sb.checked, input_stalls);
    if (sb.errors == 0 && sb.pending_levels.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(200000 * CLK_PERIOD);
    $display("Some tests failed");
    $finish;
  end

endmodule

### fuzzy_level_danger_estimator.f
rtl/fld_pkg.sv
rtl/fld_div.sv
rtl/fuzzy_level_danger_estimator.sv
rtl/fld_checker.sv
tb/testbench.sv
